FILE: rtl/core/pvn_pkg.sv
`timescale 1ns / 1ps
// pvn_pkg: shared types, constants and the control store of the peak volume normalizer.
// No dependencies. Used by peak_volume_normalizer_unit.

package pvn_pkg;

  localparam int SampleW  = 8;
  localparam int GainW    = 16;
  localparam int PcW      = 3;
  localparam int CntW     = 4;

  localparam logic [SampleW-1:0] OffsetReset  = 8'h80;
  localparam logic [GainW-1:0]   GainDividend = 16'hFFFF;

  // step addresses
  localparam logic [PcW-1:0] ST_FETCH = 3'd0;
  localparam logic [PcW-1:0] ST_DIV   = 3'd1;
  localparam logic [PcW-1:0] ST_MUL   = 3'd2;
  localparam logic [PcW-1:0] ST_EMIT  = 3'd3;
  localparam logic [PcW-1:0] ST_MEAS  = 3'd4;

  // datapath actions
  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_LOAD = 3'd1;
  localparam logic [2:0] ACT_DIV  = 3'd2;
  localparam logic [2:0] ACT_MUL  = 3'd3;
  localparam logic [2:0] ACT_EMIT = 3'd4;
  localparam logic [2:0] ACT_PEAK = 3'd5;

  // jump conditions
  localparam logic [1:0] JC_GOTO  = 2'd0; // always to target
  localparam logic [1:0] JC_FETCH = 2'd1; // hold without beat, measure to target, else next
  localparam logic [1:0] JC_LOOP  = 2'd2; // to target until the step count ends, then next
  localparam logic [1:0] JC_HOLD  = 2'd3; // hold while the result register is full, else target

  typedef struct packed {
    logic           take;
    logic [2:0]     act;
    logic [1:0]     jc;
    logic [PcW-1:0] target;
  } ctrl_word_t;

  // control store
  function automatic ctrl_word_t ucode_rom(input logic [PcW-1:0] pc);
    ctrl_word_t w;
    w = '{take: 1'b0, act: ACT_NONE, jc: JC_GOTO, target: ST_FETCH};
    unique case (pc)
      ST_FETCH: w = '{take: 1'b1, act: ACT_LOAD, jc: JC_FETCH, target: ST_MEAS};
      ST_DIV:   w = '{take: 1'b0, act: ACT_DIV,  jc: JC_LOOP,  target: ST_DIV};
      ST_MUL:   w = '{take: 1'b0, act: ACT_MUL,  jc: JC_GOTO,  target: ST_EMIT};
      ST_EMIT:  w = '{take: 1'b0, act: ACT_EMIT, jc: JC_HOLD,  target: ST_FETCH};
      ST_MEAS:  w = '{take: 1'b0, act: ACT_PEAK, jc: JC_GOTO,  target: ST_FETCH};
      default:  w = '{take: 1'b0, act: ACT_NONE, jc: JC_GOTO,  target: ST_FETCH};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/peak_volume_normalizer_unit.sv
`timescale 1ns / 1ps
// peak_volume_normalizer_unit: two-pass peak normalizer for 8-bit audio, microcoded.
// Depends on pvn_pkg for constants, the control word type and the control store.

// Each sample first gets the offset register (reset 0x80) added mod 256. A measure beat
// (in_operation 0) raises the stored peak, or restarts it on in_first_of_pass, and yields no
// result; it takes a fetch step and a peak update step. A scale beat (in_operation 1) yields one result,
// ((sample * (0xFFFF / peak)) mod 65536 >> 8) - offset, mod 256, with out_zero_peak set and the
// gain forced to zero when the peak is zero. A scale beat takes a fetch, the bit-serial restoring
// divider that forms the gain, a multiply and a load of the result register. The result register
// decouples the output: the next beat is fetched while a result waits, but a second result waits
// until the first is taken. Write the offset only while no beat is in progress.

module peak_volume_normalizer_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_sample_offset,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [7:0]            in_sample,
  input  logic                  in_first_of_pass,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_scaled_sample,
  output logic                  out_zero_peak
);
  import pvn_pkg::*;

  logic [PcW-1:0]     pc_r, pc_nxt;
  logic [CntW-1:0]    cnt_r;
  logic [SampleW-1:0] offset_r;
  logic [SampleW-1:0] peak_r;
  logic [SampleW-1:0] b_r;
  logic               first_r;
  logic [SampleW-1:0] rem_r;
  logic [GainW-1:0]   gain_r;
  logic [GainW-1:0]   prod_r;
  logic               out_valid_r;
  logic [SampleW-1:0] out_scaled_r;
  logic               out_zero_r;

  ctrl_word_t         cw;
  logic               in_beat;
  logic               out_busy;
  logic               peak_zero;
  logic [SampleW:0]   trial;
  logic               q_bit;
  logic [23:0]        prod_full;

  assign cw        = ucode_rom(pc_r);
  assign in_ready  = cw.take;
  assign in_beat   = in_valid && cw.take;
  assign out_busy  = out_valid_r && !out_ready;
  assign peak_zero = (peak_r == '0);
  assign cfg_ready = 1'b1;

  // divider trial subtract
  assign trial     = {rem_r, gain_r[GainW-1]};
  assign q_bit     = (trial >= {1'b0, peak_r});
  assign prod_full = b_r * gain_r;

  // sequencer
  always_comb begin
    pc_nxt = pc_r + 3'd1;
    unique case (cw.jc)
      JC_GOTO:  pc_nxt = cw.target;
      JC_FETCH: begin
        if (!in_beat) pc_nxt = pc_r;
        else if (!in_operation) pc_nxt = cw.target;
        else pc_nxt = pc_r + 3'd1;
      end
      JC_LOOP:  pc_nxt = (cnt_r == {CntW{1'b1}}) ? pc_r + 3'd1 : cw.target;
      JC_HOLD:  pc_nxt = out_busy ? pc_r : cw.target;
      default:  pc_nxt = ST_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OffsetReset;
    end else if (cfg_valid && cfg_ready) begin
      offset_r <= cfg_sample_offset;
    end
  end

  // peak register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else if (cw.act == ACT_PEAK && (first_r || b_r > peak_r)) begin
      peak_r <= b_r;
    end
  end

  // gain register, divider state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
    end else if (cw.act == ACT_LOAD && in_beat) begin
      gain_r <= peak_zero ? '0 : GainDividend;
    end else if (cw.act == ACT_DIV && !peak_zero) begin
      gain_r <= {gain_r[GainW-2:0], q_bit};
    end
  end

  // beat capture, remainder, step count, product
  always_ff @(posedge clk) begin
    if (cw.act == ACT_LOAD && in_beat) begin
      b_r     <= in_sample + offset_r;
      first_r <= in_first_of_pass;
      rem_r   <= '0;
      cnt_r   <= '0;
    end else if (cw.act == ACT_DIV) begin
      cnt_r <= cnt_r + 4'd1;
      if (!peak_zero) begin
        rem_r <= q_bit ? trial[SampleW-1:0] - peak_r : trial[SampleW-1:0];
      end
    end
    if (cw.act == ACT_MUL) begin
      prod_r <= prod_full[GainW-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cw.act == ACT_EMIT && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.act == ACT_EMIT && !out_busy) begin
      out_scaled_r <= prod_r[GainW-1:SampleW] - offset_r;
      out_zero_r   <= peak_zero;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_scaled_sample = out_scaled_r;
  assign out_zero_peak     = out_zero_r;

`ifndef SYNTHESIS
  a_meas_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_operation |=> pc_r == ST_MEAS)
    else $error("measure beat not dispatched to peak update");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == ST_MUL && !peak_zero |-> rem_r < peak_r)
    else $error("divider remainder not below peak");

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_zero_r |-> out_scaled_r == 8'(8'd0 - offset_r))
    else $error("zero peak result is not minus offset");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == ST_MUL |-> $past(pc_r) == ST_DIV && $past(cnt_r) == {CntW{1'b1}})
    else $error("divider left before sixteen steps");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking regression for peak_volume_normalizer_unit with a built-in predictor.
// Depends on the RTL only: peak_volume_normalizer_unit and its package pvn_pkg.

module testbench;

  // operation codes of the input beat
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_SCALE   = 1'b1;

  localparam logic [15:0] GAIN_NUMERATOR  = 16'hFFFF;
  localparam logic [7:0]  OFFSET_AT_RESET = 8'h80;

  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned SETTLE_CYCLES = 40;   // longer than one scale beat plus a measure beat
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned RANDOM_ITEMS = 550;

  typedef struct packed {
    logic [7:0] scaled_sample;
    logic       zero_peak;
  } norm_result_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_sample_offset;
  logic       in_valid;
  logic       in_ready;
  logic       in_operation;
  logic [7:0] in_sample;
  logic       in_first_of_pass;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_scaled_sample;
  logic       out_zero_peak;

  // predictor state
  logic [7:0]  model_offset;
  logic [7:0]  model_peak;
  logic [15:0] model_gain;
  norm_result_t pending_results[$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          send_idle_en;
  bit          recv_idle_en;

  peak_volume_normalizer_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_sample_offset (cfg_sample_offset),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_sample         (in_sample),
    .in_first_of_pass  (in_first_of_pass),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scaled_sample (out_scaled_sample),
    .out_zero_peak     (out_zero_peak)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("peak_volume_normalizer_unit regression: fail");
    $finish;
  end

  // Predictor: applies one accepted beat, queues the result of a scale beat.
  function automatic void model_beat(input logic op, input logic [7:0] raw, input logic first);
    logic [7:0]   biased;
    logic [15:0]  product;
    norm_result_t res;
    biased = raw + model_offset;
    if (op == OP_MEASURE) begin
      if (first || biased > model_peak) model_peak = biased;
    end else begin
      res.zero_peak = (model_peak == 8'd0);
      model_gain = res.zero_peak ? 16'd0 : GAIN_NUMERATOR / model_peak;
      product = biased * model_gain;   // kept to 16 bits, wraps
      res.scaled_sample = product[15:8] - model_offset;
      pending_results.push_back(res);
    end
  endfunction

  // Send one beat; valid stays up across back-to-back beats.
  task automatic send_sample(input logic op, input logic [7:0] raw, input logic first);
    int unsigned gap;
    gap = send_idle_en ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_sample        <= raw;
    in_first_of_pass <= first;
    do @(posedge clk); while (in_ready !== 1'b1);
    model_beat(op, raw, first);
  endtask

  // Let the block go idle: all results taken and any measure beat finished.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_offset(input logic [7:0] value);
    wait_idle();
    cfg_valid         <= 1'b1;
    cfg_sample_offset <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    model_offset = value;
  endtask

  // Result side: random back-pressure per beat.
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = recv_idle_en ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && rst_n === 1'b1));
    end
  end

  // Result checker
  always @(posedge clk) begin
    norm_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result beat: scaled_sample %02h zero_peak %0b",
                   out_scaled_sample, out_zero_peak);
      end else begin
        want = pending_results.pop_front();
        if (out_scaled_sample !== want.scaled_sample || out_zero_peak !== want.zero_peak) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result mismatch: expected scaled_sample %02h zero_peak %0b, got %02h %0b",
                     want.scaled_sample, want.zero_peak, out_scaled_sample, out_zero_peak);
        end
      end
    end
  end

  // Scale beats straight after reset see a zero peak.
  task automatic check_reset_zero_peak();
    send_sample(OP_SCALE, 8'h00, 1'b1);
    send_sample(OP_SCALE, 8'hFF, 1'b0);
  endtask

  // Full-scale peak, then samples at the field extremes; the mark on scale does nothing.
  task automatic check_peak_extremes();
    send_sample(OP_MEASURE, 8'h7F, 1'b1);
    send_sample(OP_MEASURE, 8'h00, 1'b0);
    send_sample(OP_SCALE, 8'h7F, 1'b1);
    send_sample(OP_SCALE, 8'h80, 1'b0);
    send_sample(OP_SCALE, 8'h00, 1'b1);
    send_sample(OP_SCALE, 8'hFF, 1'b0);
  endtask

  // A first-of-pass mark restarts the peak; samples above the peak wrap the product.
  task automatic check_pass_restart();
    send_sample(OP_MEASURE, 8'h90, 1'b1);
    send_sample(OP_MEASURE, 8'h85, 1'b0);
    send_sample(OP_SCALE, 8'h90, 1'b1);
    send_sample(OP_SCALE, 8'hFF, 1'b0);
    // measured peak of zero
    send_sample(OP_MEASURE, 8'h80, 1'b1);
    send_sample(OP_SCALE, 8'h12, 1'b0);
  endtask

  // Offset at both ends of its range, including a peak of one.
  task automatic check_offset_extremes();
    write_offset(8'h00);
    send_sample(OP_MEASURE, 8'h01, 1'b1);
    send_sample(OP_SCALE, 8'h01, 1'b1);
    send_sample(OP_SCALE, 8'h02, 1'b0);
    send_sample(OP_MEASURE, 8'hFF, 1'b1);
    send_sample(OP_SCALE, 8'hFF, 1'b0);
    send_sample(OP_SCALE, 8'h00, 1'b0);
    write_offset(8'hFF);
    send_sample(OP_MEASURE, 8'h01, 1'b1);
    send_sample(OP_SCALE, 8'h00, 1'b1);
    send_sample(OP_MEASURE, 8'h00, 1'b1);
    send_sample(OP_SCALE, 8'h80, 1'b0);
  endtask

  // Mostly measure-then-scale frames with random content, some zero-peak frames and noise.
  task automatic run_random_frames(input int unsigned total);
    int unsigned phase_items, per_phase, kind, len, k;
    logic [7:0]  offset_pick;
    per_phase = total / 6;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       offset_pick = 8'h00;
        1:       offset_pick = 8'hFF;
        2:       offset_pick = OFFSET_AT_RESET;
        default: offset_pick = 8'($urandom_range(0, 255));
      endcase
      write_offset(offset_pick);
      phase_items = 0;
      while (phase_items < per_phase) begin
        kind = $urandom_range(0, 9);
        send_idle_en = ($urandom_range(0, 3) != 0);
        recv_idle_en = ($urandom_range(0, 3) != 0);
        if (kind < 9) begin
          // measure pass; one kind of frame measures only silence
          len = $urandom_range(1, 8);
          for (k = 0; k < len; k++)
            send_sample(OP_MEASURE, (kind == 8) ? 8'(-model_offset) : 8'($urandom_range(0, 255)),
                        k == 0);
          phase_items += len;
          len = $urandom_range(1, 10);
          for (k = 0; k < len; k++)
            send_sample(OP_SCALE, 8'($urandom_range(0, 255)), k == 0);
          phase_items += len;
        end else begin
          len = $urandom_range(1, 6);
          for (k = 0; k < len; k++)
            send_sample(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
          phase_items += len;
        end
      end
    end
  endtask

  initial begin
    mismatch_count    = 0;
    send_idle_en      = 1'b1;
    recv_idle_en      = 1'b1;
    model_offset      = OFFSET_AT_RESET;
    model_peak        = 8'd0;
    model_gain        = 16'd0;
    rst_n            <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_sample_offset <= 8'h00;
    in_valid         <= 1'b0;
    in_operation     <= OP_MEASURE;
    in_sample        <= 8'h00;
    in_first_of_pass <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_reset_zero_peak();
    check_peak_extremes();
    check_pass_restart();
    check_offset_extremes();
    run_random_frames(RANDOM_ITEMS);

    // drain and report
    wait_idle();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("peak_volume_normalizer_unit regression: pass");
    end else begin
      $display("peak_volume_normalizer_unit regression: fail");
    end
    $finish;
  end

endmodule
